@@ src/sisp_pkg.sv @@
// Shared widths, register codes, fixed-point constants and angle table build for the stripe pixel block.
package sisp_pkg;

   // Field widths
   localparam int IDX_W      = 12;
   localparam int COLOR_W    = 8;
   localparam int STEP_W     = 21;
   localparam int RECIP_W    = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_COORD_STEP   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FILL_MODE    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STRIPE_RECIP = 2'd2;

   // Register reset values
   localparam logic [STEP_W-1:0]  COORD_STEP_RST   = 21'd16400;
   localparam logic               FILL_MODE_RST    = 1'b0;
   localparam logic [RECIP_W-1:0] STRIPE_RECIP_RST = 32'd6554;

   // Default parameter values
   localparam int MAX_SIZE_DEF   = 4096;
   localparam int ACOS_DEPTH_DEF = 1024;

   // Fixed-point formats
   localparam int PROD_W  = 33;  // index times step
   localparam int MAG_W   = 25;  // Q0.24 magnitude up to 1.0
   localparam int SQ_W    = 50;  // square of a magnitude, Q0.48
   localparam int R2_W    = 51;  // sum of two squares
   localparam int T_W     = 33;  // 4 r2 in Q0.32, up to 1.0
   localparam int FRAC_W  = 32;
   localparam int ANGLE_W = 23;  // Q7.16 degrees, up to 90

   localparam logic [PROD_W-1:0] HALF_Q24      = 33'h0_0080_0000;
   localparam logic [PROD_W-1:0] ONE_Q24       = 33'h0_0100_0000;
   localparam logic [MAG_W-1:0]  INV_SQRT2_Q24 = 25'd11863283;
   localparam logic [MAG_W-1:0]  UNITY_Q24     = 25'h100_0000;
   localparam logic [SQ_W-1:0]   ROUND_Q24     = 50'h80_0000;
   localparam logic [R2_W-1:0]   QUARTER_Q48   = 51'h4000_0000_0000;
   localparam logic [T_W-1:0]    ONE_Q32       = 33'h1_0000_0000;
   localparam logic [ANGLE_W-1:0] RIGHT_ANGLE_Q16 = 23'd5898240;

   // Arctangent steps in Q.16 degrees
   localparam int CORDIC_STEPS = 23;
   localparam logic [ANGLE_W-1:0] ATAN_DEG_Q16 [CORDIC_STEPS] = '{
      23'd2949120, 23'd1740967, 23'd919879, 23'd466945, 23'd234379, 23'd117304,
      23'd58666, 23'd29335, 23'd14668, 23'd7334, 23'd3667, 23'd1833, 23'd917,
      23'd458, 23'd229, 23'd115, 23'd57, 23'd29, 23'd14, 23'd7, 23'd4, 23'd2,
      23'd1
   };

   // Unsigned restoring division, used only while building the table
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] quo;
      logic [64:0] rem;
      quo = '0;
      rem = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[63:0], num[i]};
         if (rem >= {1'b0, den}) begin
            rem = rem - {1'b0, den};
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   // Integer square root, bit by bit
   function automatic logic [63:0] isqrt64(input logic [63:0] val);
      logic [63:0] res;
      logic [63:0] bit_v;
      logic [63:0] v;
      v = val;
      res = '0;
      bit_v = 64'h4000_0000_0000_0000;
      for (int i = 0; i < 32; i++) begin
         if (bit_v > v) bit_v = bit_v >> 2;
      end
      for (int i = 0; i < 32; i++) begin
         if (bit_v != '0) begin
            if (v >= res + bit_v) begin
               v = v - (res + bit_v);
               res = (res >> 1) + bit_v;
            end else begin
               res = res >> 1;
            end
            bit_v = bit_v >> 2;
         end
      end
      return res;
   endfunction

   // Shift right, rounding toward zero
   function automatic logic signed [63:0] shr_zero(input logic signed [63:0] v, input int s);
      logic signed [63:0] r;
      if (v >= 0) r = v >>> s;
      else r = -((-v) >>> s);
      return r;
   endfunction

   // Table entry k: asin(sqrt(k/(depth-1))) in Q7.16 degrees by CORDIC vectoring
   function automatic logic [ANGLE_W-1:0] rom_entry(input int k, input int depth);
      logic [63:0] t46;
      logic signed [63:0] x;
      logic signed [63:0] y;
      logic signed [63:0] xs;
      logic signed [63:0] ys;
      logic signed [63:0] ang;
      t46 = udiv64(64'(k) << 46, 64'(depth - 1));
      y = signed'(isqrt64(t46));
      x = signed'(isqrt64(64'h0000_4000_0000_0000 - t46));
      ang = '0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         xs = shr_zero(x, i);
         ys = shr_zero(y, i);
         if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            ang = ang + signed'(64'(ATAN_DEG_Q16[i]));
         end else begin
            x = x - ys;
            y = y + xs;
            ang = ang - signed'(64'(ATAN_DEG_Q16[i]));
         end
      end
      if (ang < 0) ang = '0;
      if (ang > signed'(64'(RIGHT_ANGLE_Q16))) ang = signed'(64'(RIGHT_ANGLE_Q16));
      return ANGLE_W'(ang);
   endfunction

endpackage

@@ src/sphere_isophote_stripe_pixel.sv @@
// Top level: pixel index to stripe color pipeline with configuration registers and angle table.
//
// Streams one pixel per clock while the output side is ready: every cycle a (row, column)
// transaction may enter and one RGB transaction may leave. Each pixel passes twelve register
// stages (index multiply, magnitude, fill scaling, rounding, square, radius sum, table
// position, angle table read, difference, interpolation multiply, angle sum, stripe multiply).
// Every stage holds its own valid bit and loads whenever it is empty or the stage after it
// moves, so bubbles close up and requests are taken while a finished pixel waits at the
// output. The angle table has ACOS_TABLE_DEPTH entries, built at elaboration, and is read at
// two addresses in stage eight with registered data. Configuration registers are written
// through the csr channel, which is always ready, and are to be changed only while no pixel is
// in flight.
module sphere_isophote_stripe_pixel #(
   parameter int MAX_SIZE         = sisp_pkg::MAX_SIZE_DEF,
   parameter int ACOS_TABLE_DEPTH = sisp_pkg::ACOS_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // request: [11:0] row_index, [23:12] col_index
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [2*sisp_pkg::IDX_W-1:0]     req_tdata,
   // response: [7:0] red, [15:8] green, [23:16] blue
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [3*sisp_pkg::COLOR_W-1:0]   rsp_tdata,
   // configuration write channel
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [sisp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sisp_pkg::CSR_DATA_W-1:0]  csr_data
);

   localparam int NST     = 12;
   localparam int CNT_W   = $clog2(NST + 1);
   localparam int SIZE_W  = $clog2(MAX_SIZE);
   localparam int CMP_W   = (SIZE_W > sisp_pkg::IDX_W) ? SIZE_W : sisp_pkg::IDX_W;
   localparam int ROM_AW  = $clog2(ACOS_TABLE_DEPTH);
   localparam int POS_W   = sisp_pkg::T_W + ROM_AW;
   localparam int DP_W    = sisp_pkg::ANGLE_W + sisp_pkg::FRAC_W;
   localparam int Q_W     = sisp_pkg::ANGLE_W + sisp_pkg::RECIP_W;
   localparam logic [CMP_W-1:0]  LAST_IDX = CMP_W'(MAX_SIZE - 1);
   localparam logic [ROM_AW:0]   LAST_K   = (ROM_AW + 1)'(ACOS_TABLE_DEPTH - 1);
   localparam logic [ROM_AW-1:0] LAST_A   = ROM_AW'(ACOS_TABLE_DEPTH - 1);

   // Configuration registers
   logic [sisp_pkg::STEP_W-1:0]  coord_step_ff;
   logic                         fill_mode_ff;
   logic [sisp_pkg::RECIP_W-1:0] stripe_recip_ff;

   // Pipeline control
   logic v_ff [1:NST];
   logic v_in [1:NST];
   logic en   [1:NST];

   // Stage data
   logic [sisp_pkg::PROD_W-1:0]  p_ff   [2];
   logic [sisp_pkg::PROD_W-1:0]  p_in   [2];
   logic [sisp_pkg::MAG_W-1:0]   m_ff   [2];
   logic [sisp_pkg::MAG_W-1:0]   m_in   [2];
   logic [sisp_pkg::SQ_W-1:0]    f_ff   [2];
   logic [sisp_pkg::SQ_W-1:0]    f_in   [2];
   logic [sisp_pkg::MAG_W-1:0]   a_ff   [2];
   logic [sisp_pkg::MAG_W-1:0]   a_in   [2];
   logic [sisp_pkg::SQ_W-1:0]    s_ff   [2];
   logic [sisp_pkg::SQ_W-1:0]    s_in   [2];
   logic [sisp_pkg::IDX_W-1:0]   idx_c  [2];
   logic [sisp_pkg::MAG_W-1:0]   scale;
   logic [sisp_pkg::R2_W-1:0]    r2;
   logic [sisp_pkg::T_W-1:0]     t_ff;
   logic [sisp_pkg::T_W-1:0]     t_in;
   logic [POS_W-1:0]             pos_ff;
   logic [POS_W-1:0]             pos_in;
   logic [ROM_AW:0]              k_raw;
   logic [ROM_AW-1:0]            ka;
   logic [ROM_AW-1:0]            kb;
   logic [sisp_pkg::FRAC_W-1:0]  frac8_in;
   logic [sisp_pkg::FRAC_W-1:0]  frac8_ff;
   logic [sisp_pkg::ANGLE_W-1:0] ta_ff;
   logic [sisp_pkg::ANGLE_W-1:0] tb_ff;
   logic                         neg_in;
   logic                         neg9_ff;
   logic                         neg10_ff;
   logic [sisp_pkg::ANGLE_W-1:0] diff_in;
   logic [sisp_pkg::ANGLE_W-1:0] diff_ff;
   logic [sisp_pkg::ANGLE_W-1:0] a9_ff;
   logic [sisp_pkg::ANGLE_W-1:0] a10_ff;
   logic [sisp_pkg::FRAC_W-1:0]  frac9_ff;
   logic [DP_W-1:0]              dp_in;
   logic [DP_W-1:0]              dp_ff;
   logic [sisp_pkg::ANGLE_W-1:0] delta;
   logic [sisp_pkg::ANGLE_W-1:0] angle_in;
   logic [sisp_pkg::ANGLE_W-1:0] angle_ff;
   logic [Q_W-1:0]               q;
   logic                         odd_in;
   logic                         odd_ff;
   logic                         ins_in;
   logic                         ins_ff [6:NST];
   logic [CNT_W-1:0]             cnt_ff;
   logic [CNT_W-1:0]             cnt_in;

   // Angle table, one constant per entry
   logic [sisp_pkg::ANGLE_W-1:0] angle_rom [ACOS_TABLE_DEPTH];
   for (genvar g = 0; g < ACOS_TABLE_DEPTH; g++) begin : g_rom
      localparam logic [sisp_pkg::ANGLE_W-1:0] ENTRY =
         sisp_pkg::rom_entry(g, ACOS_TABLE_DEPTH);
      assign angle_rom[g] = ENTRY;
   end

   // Configuration writes; unknown indexes are dropped
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         coord_step_ff   <= sisp_pkg::COORD_STEP_RST;
         fill_mode_ff    <= sisp_pkg::FILL_MODE_RST;
         stripe_recip_ff <= sisp_pkg::STRIPE_RECIP_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            sisp_pkg::CSR_COORD_STEP:   coord_step_ff   <= csr_data[sisp_pkg::STEP_W-1:0];
            sisp_pkg::CSR_FILL_MODE:    fill_mode_ff    <= csr_data[0];
            sisp_pkg::CSR_STRIPE_RECIP: stripe_recip_ff <= csr_data[sisp_pkg::RECIP_W-1:0];
            default: ;
         endcase
      end
   end

   // Stage enables: a stage loads when empty or when the next stage moves
   always_comb begin
      en[NST] = !v_ff[NST] || rsp_tready;
      for (int i = NST - 1; i >= 1; i--) begin
         en[i] = !v_ff[i] || en[i + 1];
      end
      if (en[1]) v_in[1] = req_tvalid;
      else v_in[1] = v_ff[1];
      for (int i = 2; i <= NST; i++) begin
         if (en[i]) v_in[i] = v_ff[i - 1];
         else v_in[i] = v_ff[i];
      end
   end

   assign req_tready = en[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 1; i <= NST; i++) v_ff[i] <= 1'b0;
      end else begin
         for (int i = 1; i <= NST; i++) v_ff[i] <= v_in[i];
      end
   end

   // Coordinate path for both axes
   assign idx_c[0] = req_tdata[sisp_pkg::IDX_W-1:0];
   assign idx_c[1] = req_tdata[2*sisp_pkg::IDX_W-1:sisp_pkg::IDX_W];
   assign scale    = fill_mode_ff ? sisp_pkg::INV_SQRT2_Q24 : sisp_pkg::UNITY_Q24;

   always_comb begin
      for (int a = 0; a < 2; a++) begin
         // clamp index and multiply by step
         if (CMP_W'(idx_c[a]) > LAST_IDX) begin
            p_in[a] = sisp_pkg::PROD_W'(LAST_IDX[sisp_pkg::IDX_W-1:0]) *
                      sisp_pkg::PROD_W'(coord_step_ff);
         end else begin
            p_in[a] = sisp_pkg::PROD_W'(idx_c[a]) * sisp_pkg::PROD_W'(coord_step_ff);
         end
         // distance from center, saturated at one
         if (p_ff[a] >= sisp_pkg::HALF_Q24) begin
            m_in[a] = (p_ff[a] - sisp_pkg::HALF_Q24 > sisp_pkg::ONE_Q24) ? sisp_pkg::UNITY_Q24 :
                      sisp_pkg::MAG_W'(p_ff[a] - sisp_pkg::HALF_Q24);
         end else begin
            m_in[a] = sisp_pkg::MAG_W'(sisp_pkg::HALF_Q24 - p_ff[a]);
         end
         // fill scaling (unity keeps the magnitude after rounding)
         f_in[a] = sisp_pkg::SQ_W'(m_ff[a]) * sisp_pkg::SQ_W'(scale);
         a_in[a] = sisp_pkg::MAG_W'((f_ff[a] + sisp_pkg::ROUND_Q24) >> 24);
         s_in[a] = sisp_pkg::SQ_W'(a_ff[a]) * sisp_pkg::SQ_W'(a_ff[a]);
      end
   end

   // Radius test and table position
   assign r2     = sisp_pkg::R2_W'(s_ff[0]) + sisp_pkg::R2_W'(s_ff[1]);
   assign ins_in = (r2 <= sisp_pkg::QUARTER_Q48);
   assign t_in   = r2[46:14];
   assign pos_in = POS_W'(t_ff) * POS_W'(ACOS_TABLE_DEPTH - 1);
   assign k_raw  = pos_ff[POS_W-1:32];

   // Table addresses; the last entry stands alone
   always_comb begin
      if (k_raw >= LAST_K) begin
         ka       = LAST_A;
         kb       = LAST_A;
         frac8_in = '0;
      end else begin
         ka       = k_raw[ROM_AW-1:0];
         kb       = k_raw[ROM_AW-1:0] + ROM_AW'(1);
         frac8_in = pos_ff[31:0];
      end
   end

   // Interpolation and stripe parity
   assign neg_in   = tb_ff < ta_ff;
   assign diff_in  = neg_in ? (ta_ff - tb_ff) : (tb_ff - ta_ff);
   assign dp_in    = DP_W'(diff_ff) * DP_W'(frac9_ff);
   assign delta    = dp_ff[DP_W-1:sisp_pkg::FRAC_W];
   assign angle_in = neg10_ff ? (a10_ff - delta) : (a10_ff + delta);
   assign q        = Q_W'(angle_ff) * Q_W'(stripe_recip_ff);
   assign odd_in   = q[32];

   // Stage registers: each loads on its own enable
   always_ff @(posedge clock) begin
      for (int a = 0; a < 2; a++) begin
         if (en[1]) p_ff[a] <= p_in[a];
         if (en[2]) m_ff[a] <= m_in[a];
         if (en[3]) f_ff[a] <= f_in[a];
         if (en[4]) a_ff[a] <= a_in[a];
         if (en[5]) s_ff[a] <= s_in[a];
      end
      if (en[6]) begin
         t_ff      <= t_in;
         ins_ff[6] <= ins_in;
      end
      if (en[7]) pos_ff <= pos_in;
      if (en[8]) begin
         ta_ff    <= angle_rom[ka];
         tb_ff    <= angle_rom[kb];
         frac8_ff <= frac8_in;
      end
      if (en[9]) begin
         neg9_ff  <= neg_in;
         diff_ff  <= diff_in;
         a9_ff    <= ta_ff;
         frac9_ff <= frac8_ff;
      end
      if (en[10]) begin
         dp_ff    <= dp_in;
         a10_ff   <= a9_ff;
         neg10_ff <= neg9_ff;
      end
      if (en[11]) angle_ff <= angle_in;
      if (en[12]) odd_ff <= odd_in;
      for (int i = 7; i <= NST; i++) begin
         if (en[i]) ins_ff[i] <= ins_ff[i - 1];
      end
   end

   // Output transaction
   assign rsp_tvalid = v_ff[NST];
   assign rsp_tdata[sisp_pkg::COLOR_W-1:0] = ins_ff[NST] ? '1 : '0;
   assign rsp_tdata[2*sisp_pkg::COLOR_W-1:sisp_pkg::COLOR_W] =
      (ins_ff[NST] && odd_ff) ? '1 : '0;
   assign rsp_tdata[3*sisp_pkg::COLOR_W-1:2*sisp_pkg::COLOR_W] =
      (ins_ff[NST] && odd_ff) ? '1 : '0;

   // Count pixels in flight
   always_comb begin
      cnt_in = cnt_ff;
      if (req_tvalid && req_tready) cnt_in = cnt_in + CNT_W'(1);
      if (rsp_tvalid && rsp_tready) cnt_in = cnt_in - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= '0;
      else cnt_ff <= cnt_in;
   end

   // Every accepted pixel sits in exactly one stage until it leaves
   a_occupancy: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == CNT_W'($countones({v_ff[1], v_ff[2], v_ff[3], v_ff[4], v_ff[5], v_ff[6],
                                   v_ff[7], v_ff[8], v_ff[9], v_ff[10], v_ff[11], v_ff[12]})))
      else $error("pipeline occupancy does not match accepted minus delivered pixels");

   // Inside the disc the table position stays within one
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      (v_ff[6] && ins_ff[6]) |-> (t_ff <= sisp_pkg::ONE_Q32))
      else $error("table position above one for a pixel inside the disc");

   // Table reads never exceed a right angle
   a_rom_range: assert property (@(posedge clock) disable iff (reset)
      v_ff[8] |-> (ta_ff <= sisp_pkg::RIGHT_ANGLE_Q16 && tb_ff <= sisp_pkg::RIGHT_ANGLE_Q16))
      else $error("angle table entry above a right angle");

   // Interpolated angle stays within range
   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      (v_ff[11] && ins_ff[11]) |-> (angle_ff <= sisp_pkg::RIGHT_ANGLE_Q16))
      else $error("interpolated angle above a right angle");

   // A held stage keeps its angle while the next stage is full and does not move
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (v_ff[11] && !en[11]) |=> $stable(angle_ff))
      else $error("stalled angle stage changed its data");

endmodule

@@ bench/tb_sphere_isophote_stripe_pixel.sv @@
// Self-checking bench: sphere stripe pixel colors checked against a built-in fixed-point predictor.
module tb_sphere_isophote_stripe_pixel;

   localparam int INDEX_LIMIT       = 4096;
   localparam int ANGLE_TABLE_DEPTH = 1024;
   localparam int CYCLE_LIMIT       = 200000;
   localparam int ITEMS_PER_SETTING = 75;

   // Register index that decodes to nothing
   localparam logic [sisp_pkg::CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   // Fixed-point constants of the pixel math
   localparam logic [63:0] HALF_POS     = 64'd1 << 23;
   localparam logic [63:0] UNIT_POS     = 64'd1 << 24;
   localparam logic [63:0] RSQRT2_Q24   = 64'd11863283;
   localparam logic [63:0] R2_QUARTER   = 64'd1 << 46;
   localparam longint      RIGHT_ANGLE  = 64'sd5898240;
   localparam int          ROTATIONS    = 23;
   localparam logic [20:0] STEP_DEFAULT = 21'd16400;
   localparam logic [31:0] RECIP_DEFAULT = 32'd6554;

   localparam logic [7:0] CH_FULL = 8'hFF;
   localparam logic [7:0] CH_NONE = 8'h00;

   // Rotation angles atan(2^-i) in Q.16 degrees
   localparam longint ROTATION_DEG [ROTATIONS] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1
   };

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_rgb_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // [11:0] row_index, [23:12] col_index
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // [7:0] red, [15:8] green, [23:16] blue
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [sisp_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [sisp_pkg::CSR_DATA_W-1:0] csr_data = '0;

   // Predictor copy of the registers
   logic [20:0] step_q24  = STEP_DEFAULT;
   logic        fill_on   = 1'b0;
   logic [31:0] recip_q16 = RECIP_DEFAULT;
   int          image_extent = 1024;

   logic [22:0]   half_angle_table [ANGLE_TABLE_DEPTH];
   pixel_rgb_type pending_pixels [$];
   int            mismatch_count = 0;
   int            cycle_count = 0;
   int            send_idle_pct = 0;
   int            stall_pct = 0;

   sphere_isophote_stripe_pixel #(
      .MAX_SIZE        (INDEX_LIMIT),
      .ACOS_TABLE_DEPTH(ANGLE_TABLE_DEPTH)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial forever #5 clock = ~clock;

   // Floor square root by trial bits
   function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
      logic [63:0] root;
      logic [63:0] trial;
      root = '0;
      for (int b = 31; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= v) root = trial;
      end
      return root;
   endfunction

   function automatic longint trunc_shift(input longint v, input int s);
      if (v >= 0) return v >>> s;
      return -((-v) >>> s);
   endfunction

   // asin(sqrt(k/(depth-1))) in Q7.16 degrees, rotating the vector onto the x axis
   function automatic logic [22:0] half_angle_entry(input int k);
      logic [63:0] t46;
      longint x, y, xs, ys, ang;
      t46 = (64'(k) << 46) / 64'(ANGLE_TABLE_DEPTH - 1);
      y = longint'(floor_sqrt(t46));
      x = longint'(floor_sqrt(R2_QUARTER - t46));
      ang = 0;
      for (int i = 0; i < ROTATIONS; i++) begin
         xs = trunc_shift(x, i);
         ys = trunc_shift(y, i);
         if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            ang = ang + ROTATION_DEG[i];
         end else begin
            x = x - ys;
            y = y + xs;
            ang = ang - ROTATION_DEG[i];
         end
      end
      if (ang < 0) ang = 0;
      if (ang > RIGHT_ANGLE) ang = RIGHT_ANGLE;
      return 23'(ang);
   endfunction

   // Distance of an index from the image center in Q0.24, saturated, optionally scaled
   function automatic logic [63:0] centred_mag(input logic [11:0] idx);
      logic [63:0] p, m;
      p = 64'(idx) * 64'(step_q24);
      m = (p >= HALF_POS) ? p - HALF_POS : HALF_POS - p;
      if (m > UNIT_POS) m = UNIT_POS;
      if (fill_on) m = (m * RSQRT2_Q24 + HALF_POS) >> 24;
      return m;
   endfunction

   function automatic pixel_rgb_type predict_pixel(input logic [11:0] row,
                                                   input logic [11:0] col);
      logic [63:0] xm, ym, r2, pos, k, frac, a, b, angle, q;
      pixel_rgb_type px;
      xm = centred_mag(row);
      ym = centred_mag(col);
      r2 = xm * xm + ym * ym;
      if (r2 > R2_QUARTER) begin
         px = '{red: CH_NONE, green: CH_NONE, blue: CH_NONE};
         return px;
      end
      pos = (r2 >> 14) * 64'(ANGLE_TABLE_DEPTH - 1);
      k = pos >> 32;
      frac = {32'd0, pos[31:0]};
      if (k >= 64'(ANGLE_TABLE_DEPTH - 1)) begin
         angle = 64'(half_angle_table[ANGLE_TABLE_DEPTH-1]);
      end else begin
         a = 64'(half_angle_table[int'(k)]);
         b = 64'(half_angle_table[int'(k) + 1]);
         if (b >= a) angle = a + (((b - a) * frac) >> 32);
         else angle = a - (((a - b) * frac) >> 32);
      end
      q = angle * 64'(recip_q16);
      px.red = CH_FULL;
      px.green = q[32] ? CH_FULL : CH_NONE;
      px.blue = px.green;
      return px;
   endfunction

   // Offer one pixel after a random idle gap, record its color on acceptance
   task automatic send_pixel(input logic [11:0] row, input logic [11:0] col);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= {col, row};
      do @(posedge clock); while (!req_tready);
      pending_pixels.push_back(predict_pixel(row, col));
   endtask

   // Drop valid and hold until every outstanding pixel has returned
   task automatic await_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input logic [sisp_pkg::CSR_IDX_W-1:0] index,
                                 input logic [31:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         sisp_pkg::CSR_COORD_STEP: begin
            step_q24 = value[20:0];
            if (step_q24 == 0) image_extent = INDEX_LIMIT;
            else image_extent = ((1 << 24) / int'(step_q24)) + 1;
            if (image_extent > INDEX_LIMIT) image_extent = INDEX_LIMIT;
         end
         sisp_pkg::CSR_FILL_MODE:    fill_on = value[0];
         sisp_pkg::CSR_STRIPE_RECIP: recip_q16 = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Random stall on the result side
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // Compare each result transaction with the oldest predicted color
   always @(posedge clock) begin : check_pixels
      pixel_rgb_type want;
      pixel_rgb_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (pending_pixels.size() == 0) begin
            $display("%0t: unexpected pixel r=%0d g=%0d b=%0d", $time,
                     got.blue, got.green, got.red);
            mismatch_count++;
         end else begin
            want = pending_pixels.pop_front();
            // tdata holds red low, so the packed struct reads reversed
            if (want.red != got.blue) begin
               $display("%0t: red expected %0d, got %0d", $time, want.red, got.blue);
               mismatch_count++;
            end
            if (want.green != got.green) begin
               $display("%0t: green expected %0d, got %0d", $time, want.green, got.green);
               mismatch_count++;
            end
            if (want.blue != got.red) begin
               $display("%0t: blue expected %0d, got %0d", $time, want.blue, got.red);
               mismatch_count++;
            end
         end
      end
   end

   // Bound the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d pixels outstanding", $time, pending_pixels.size());
         $display("sphere_isophote_stripe_pixel regression: fail");
         $finish;
      end
   end

   // Corners, center, disc edge and saturated indices at reset settings
   task automatic test_default_geometry();
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd511, 12'd511);
      send_pixel(12'd512, 12'd512);
      send_pixel(12'd0, 12'd511);
      send_pixel(12'd1023, 12'd512);
      send_pixel(12'd4095, 12'd4095);
      send_pixel(12'd4095, 12'd0);
      send_pixel(12'd255, 12'd255);
      send_pixel(12'd300, 12'd700);
      await_results();
   endtask

   // Register extremes: zero step, oversized step, fill, zero and full stripe, spare index
   task automatic test_register_corners();
      write_register(sisp_pkg::CSR_COORD_STEP, 32'd0);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd4095, 12'd4095);
      await_results();
      write_register(sisp_pkg::CSR_COORD_STEP, 32'h001F_FFFF);
      send_pixel(12'd4, 12'd4);
      send_pixel(12'd4095, 12'd4095);
      await_results();
      write_register(sisp_pkg::CSR_COORD_STEP, 32'(STEP_DEFAULT));
      write_register(sisp_pkg::CSR_FILL_MODE, 32'd1);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd0, 12'd511);
      send_pixel(12'd511, 12'd511);
      await_results();
      write_register(sisp_pkg::CSR_FILL_MODE, 32'd0);
      write_register(sisp_pkg::CSR_STRIPE_RECIP, 32'd0);
      send_pixel(12'd400, 12'd600);
      send_pixel(12'd511, 12'd511);
      await_results();
      write_register(sisp_pkg::CSR_STRIPE_RECIP, 32'hFFFF_FFFF);
      send_pixel(12'd400, 12'd600);
      send_pixel(12'd700, 12'd300);
      await_results();
      write_register(CSR_SPARE, 32'hA5A5_A5A5);
      send_pixel(12'd400, 12'd600);
      await_results();
   endtask

   // Pick a fresh image size, fill mode and stripe width
   task automatic randomize_settings();
      logic [31:0] step, recip;
      case ($urandom_range(7))
         0: step = $urandom;
         1: step = $urandom_range(1, 4);
         default: step = (32'd1 << 24) / $urandom_range(1, INDEX_LIMIT - 1);
      endcase
      case ($urandom_range(7))
         0: recip = $urandom;
         1: recip = $urandom_range(1) ? 32'hFFFF_FFFF : 32'd0;
         default: recip = (32'd1 << 20) / $urandom_range(8, 1440);
      endcase
      write_register(sisp_pkg::CSR_COORD_STEP, step);
      write_register(sisp_pkg::CSR_FILL_MODE, 32'($urandom_range(1)));
      write_register(sisp_pkg::CSR_STRIPE_RECIP, recip);
   endtask

   // Random pixels under one idle pattern, three settings each
   task automatic test_random_traffic(input int idle_pct, input int hold_pct);
      logic [11:0] row, col;
      send_idle_pct = idle_pct;
      stall_pct = hold_pct;
      for (int s = 0; s < 3; s++) begin
         randomize_settings();
         for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
            // pause mid-stream once per setting until the pipe is empty
            if (n == ITEMS_PER_SETTING / 2) await_results();
            if ($urandom_range(7) == 0) begin
               row = 12'($urandom);
               col = 12'($urandom);
            end else begin
               row = 12'($urandom_range(0, image_extent - 1));
               col = 12'($urandom_range(0, image_extent - 1));
            end
            send_pixel(row, col);
         end
         await_results();
      end
   endtask

   initial begin
      for (int k = 0; k < ANGLE_TABLE_DEPTH; k++) half_angle_table[k] = half_angle_entry(k);
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_default_geometry();
      test_register_corners();
      test_random_traffic(0, 0);
      test_random_traffic(69, 0);
      test_random_traffic(0, 69);
      test_random_traffic(13, 13);

      await_results();
      repeat (24) @(posedge clock);
      if (pending_pixels.size() != 0) begin
         $display("%0t: %0d pixels never returned", $time, pending_pixels.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("sphere_isophote_stripe_pixel regression: pass");
      end else begin
         $display("sphere_isophote_stripe_pixel regression: fail");
      end
      $finish;
   end

endmodule

@@ sim.f @@
src/sisp_pkg.sv
src/sphere_isophote_stripe_pixel.sv
bench/tb_sphere_isophote_stripe_pixel.sv
